// ===== src/gwd_pkg.sv =====
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared types and constants of the grid wavefront distance map.
// ----------------------------------------------------------------------------
`default_nettype none

package gwd_pkg;

    localparam int IDX_W  = 12;
    localparam int CODE_W = 8;
    localparam int DIST_W = 14;
    localparam int DIM_W  = 7;
    localparam int STEP_W = 13;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_FREE = 8'd0;
    localparam logic [CODE_W-1:0] CODE_WALL = 8'd1;
    localparam logic [CODE_W-1:0] CODE_END  = 8'd255;

    localparam logic [STEP_W-1:0] DIST_MAX  = 13'd8191;
    localparam logic [DIST_W-1:0] DIST_WALL = 14'h3fff;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  cell_index;
        logic [CODE_W-1:0] cell_code;
    } req_t;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [IDX_W-1:0]         seed_index;
    } rsp_t;

    function automatic logic passes(input logic [CODE_W-1:0] code);
        return (code == CODE_FREE) || (code == CODE_END);
    endfunction

endpackage

`default_nettype wire

// ===== src/gwd_engine.sv =====
// ----------------------------------------------------------------------------
// gwd_engine
// Cell code, distance and work queue memories with the run sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gwd_engine
    import gwd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [DIM_W-1:0] grid_w,
    input  wire logic [DIM_W-1:0] grid_h,
    input  wire logic             req_valid,
    input  wire req_t             req,
    output logic                  ready,
    output logic                  rsp_valid,
    output rsp_t                  rsp
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW    = (AW + 1 > 2 * DIM_W + 1) ? AW + 1 : 2 * DIM_W + 1;
    localparam int QW    = AW + CW + STEP_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_SWEEP  = 4'd2;
    localparam logic [3:0] S_SWTAIL = 4'd3;
    localparam logic [3:0] S_SEED   = 4'd4;
    localparam logic [3:0] S_SEEDW  = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_POPW   = 4'd7;
    localparam logic [3:0] S_NB     = 4'd8;
    localparam logic [3:0] S_NBW    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [CODE_W-1:0] code_mem [CELLS];
    logic [DIST_W-1:0] dist_mem [CELLS];
    logic [QW-1:0]     queue_mem [CELLS];

    logic [CODE_W-1:0] code_q;
    logic [DIST_W-1:0] dist_q;
    logic [QW-1:0]     queue_q;

    logic              code_we, code_re, dist_we, dist_re, queue_we, queue_re;
    logic [AW-1:0]     code_wa, code_ra, dist_wa, dist_ra, queue_wa, queue_ra;
    logic [CODE_W-1:0] code_wd;
    logic [DIST_W-1:0] dist_wd;
    logic [QW-1:0]     queue_wd;

    logic [3:0]        state_reg, state_next;
    logic              run_reg, run_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [XW-1:0]     total_reg, total_next;
    logic [AW:0]       sw_reg, sw_next;
    logic [CW-1:0]     col_reg, col_next;
    logic              scan_v_reg, scan_v_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic [CW-1:0]     scan_col_reg, scan_col_next;
    logic [AW-1:0]     seed_reg, seed_next;
    logic [CW-1:0]     seed_col_reg, seed_col_next;
    logic [AW:0]       head_reg, head_next, tail_reg, tail_next;
    logic [1:0]        k_reg, k_next;
    logic [AW-1:0]     n_reg, n_next;
    logic [CW-1:0]     ncol_reg, ncol_next;

    // current cell being expanded, from the queue read data
    logic [AW-1:0]     cur_cell;
    logic [CW-1:0]     cur_col;
    logic [STEP_W-1:0] cur_d, nd;
    logic [XW-1:0]     cx, wx, colx;
    logic              nb_ok;
    logic [XW-1:0]     nb_x;
    logic [CW-1:0]     nb_col;
    logic              in_range;

    assign cur_cell = queue_q[QW-1 -: AW];
    assign cur_col  = queue_q[STEP_W +: CW];
    assign cur_d    = queue_q[STEP_W-1:0];
    assign nd       = (cur_d == DIST_MAX) ? DIST_MAX : cur_d + STEP_W'(1);
    assign cx       = XW'(cur_cell);
    assign wx       = XW'(grid_w);
    assign colx     = XW'(cur_col);
    assign in_range = XW'(req.cell_index) < XW'(CELLS);

    always_comb
    begin
        nb_ok  = 1'b0;
        nb_x   = cx;
        nb_col = cur_col;
        case (k_reg)
            2'd0:
            begin
                nb_ok  = (colx + XW'(1) != wx) && (cx + XW'(1) < total_reg);
                nb_x   = cx + XW'(1);
                nb_col = cur_col + CW'(1);
            end
            2'd1:
            begin
                nb_ok  = (cur_col != '0);
                nb_x   = cx - XW'(1);
                nb_col = cur_col - CW'(1);
            end
            2'd2:
            begin
                nb_ok = (cx + wx < total_reg);
                nb_x  = cx + wx;
            end
            default:
            begin
                nb_ok = (cx >= wx);
                nb_x  = cx - wx;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        rd_ok_next    = rd_ok_reg;
        total_next    = total_reg;
        sw_next       = sw_reg;
        col_next      = col_reg;
        scan_v_next   = 1'b0;
        scan_idx_next = scan_idx_reg;
        scan_col_next = scan_col_reg;
        seed_next     = seed_reg;
        seed_col_next = seed_col_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        ncol_next     = ncol_reg;
        code_we  = 1'b0; code_wa = AW'(req.cell_index); code_wd = req.cell_code;
        code_re  = 1'b0; code_ra = sw_reg[AW-1:0];
        dist_we  = 1'b0; dist_wa = sw_reg[AW-1:0];     dist_wd = '0;
        dist_re  = 1'b0; dist_ra = AW'(req.cell_index);
        queue_we = 1'b0; queue_wa = tail_reg[AW-1:0];  queue_wd = '0;
        queue_re = 1'b0; queue_ra = head_reg[AW-1:0];
        rsp_valid = 1'b0;
        rsp.distance   = '0;
        rsp.seed_index = '0;

        // last cell coded end within the grid in use becomes the seed
        if (scan_v_reg && run_reg && code_q == CODE_END &&
            XW'(scan_idx_reg) < total_reg)
        begin
            seed_next     = scan_idx_reg;
            seed_col_next = scan_col_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action)
                        ACT_WRITE:
                        begin
                            code_we = in_range;
                        end
                        ACT_READ:
                        begin
                            dist_re    = in_range;
                            rd_ok_next = in_range;
                            state_next = S_READ;
                        end
                        ACT_RUN:
                        begin
                            run_next      = 1'b1;
                            total_next    = XW'(grid_w) * XW'(grid_h);
                            sw_next       = '0;
                            col_next      = '0;
                            seed_next     = '0;
                            seed_col_next = '0;
                            state_next    = S_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_valid    = 1'b1;
                rsp.distance = rd_ok_reg ? dist_q : '0;
                state_next   = S_IDLE;
            end
            S_SWEEP:
            begin
                // clear the distance store and scan codes in one pass
                dist_we       = 1'b1;
                code_re       = 1'b1;
                scan_v_next   = 1'b1;
                scan_idx_next = sw_reg[AW-1:0];
                scan_col_next = col_reg;
                col_next      = (XW'(col_reg) + XW'(1) == wx) ? '0 : col_reg + CW'(1);
                sw_next       = sw_reg + (AW+1)'(1);
                if (XW'(sw_reg) == XW'(CELLS - 1))
                    state_next = S_SWTAIL;
            end
            S_SWTAIL:
            begin
                state_next = run_reg ? S_SEED : S_IDLE;
            end
            S_SEED:
            begin
                code_re    = 1'b1;
                code_ra    = seed_reg;
                state_next = S_SEEDW;
            end
            S_SEEDW:
            begin
                dist_we   = 1'b1;
                dist_wa   = seed_reg;
                head_next = '0;
                if (code_q == CODE_WALL)
                begin
                    dist_wd    = DIST_WALL;
                    tail_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    dist_wd  = DIST_W'(1);
                    queue_we = passes(code_q);
                    queue_wa = '0;
                    queue_wd = {seed_reg, seed_col_reg, STEP_W'(1)};
                    tail_next  = passes(code_q) ? (AW+1)'(1) : '0;
                    state_next = passes(code_q) ? S_POP : S_DONE;
                end
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                    state_next = S_DONE;
                else
                begin
                    queue_re   = 1'b1;
                    head_next  = head_reg + (AW+1)'(1);
                    k_next     = '0;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                state_next = S_NB;
            end
            S_NB:
            begin
                if (nb_ok)
                begin
                    code_re    = 1'b1;
                    code_ra    = AW'(nb_x);
                    dist_re    = 1'b1;
                    dist_ra    = AW'(nb_x);
                    n_next     = AW'(nb_x);
                    ncol_next  = nb_col;
                    state_next = S_NBW;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_POP : S_NB;
                end
            end
            S_NBW:
            begin
                dist_wa = n_reg;
                if (dist_q == '0)
                begin
                    dist_we = 1'b1;
                    if (code_q == CODE_WALL)
                        dist_wd = DIST_WALL;
                    else
                    begin
                        dist_wd = DIST_W'(nd);
                        if (passes(code_q) && XW'(tail_reg) < XW'(CELLS))
                        begin
                            queue_we  = 1'b1;
                            queue_wd  = {n_reg, ncol_reg, nd};
                            tail_next = tail_reg + (AW+1)'(1);
                        end
                    end
                end
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? S_POP : S_NB;
            end
            S_DONE:
            begin
                rsp_valid      = 1'b1;
                rsp.seed_index = IDX_W'(seed_reg);
                run_next       = 1'b0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (code_we)
            code_mem[code_wa] <= code_wd;
        if (code_re)
            code_q <= code_mem[code_ra];
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        if (dist_re)
            dist_q <= dist_mem[dist_ra];
        if (queue_we)
            queue_mem[queue_wa] <= queue_wd;
        if (queue_re)
            queue_q <= queue_mem[queue_ra];
    end

    // reset starts with a clearing pass over the distance store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            run_reg      <= 1'b0;
            rd_ok_reg    <= 1'b0;
            total_reg    <= '0;
            sw_reg       <= '0;
            col_reg      <= '0;
            scan_v_reg   <= 1'b0;
            scan_idx_reg <= '0;
            scan_col_reg <= '0;
            seed_reg     <= '0;
            seed_col_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            ncol_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            rd_ok_reg    <= rd_ok_next;
            total_reg    <= total_next;
            sw_reg       <= sw_next;
            col_reg      <= col_next;
            scan_v_reg   <= scan_v_next;
            scan_idx_reg <= scan_idx_next;
            scan_col_reg <= scan_col_next;
            seed_reg     <= seed_next;
            seed_col_reg <= seed_col_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            ncol_reg     <= ncol_next;
        end
    end

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(tail_reg) <= XW'(CELLS))
        else $error("queue overfilled");

    a_read_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(state_reg) == S_IDLE)
        else $error("read response without request");

endmodule

`default_nettype wire

// ===== src/grid_wavefront_distance_map.sv =====
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map
// Breadth-first distance map over a grid of cell codes.
// ----------------------------------------------------------------------------
// Write requests are answered at once; a read request passes through a read
// state. A run request first sweeps the whole distance store, clearing it
// while scanning codes for the seed, then expands the queue: each queued
// cell is popped and its neighbors visited in turn, an in-grid one with a
// read and an update step and one off the grid edge skipped, paced by the
// single read port of the code and distance memories. After reset the same
// clearing sweep runs before the first request is taken.
`default_nettype none

module grid_wavefront_distance_map
    import gwd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [DIM_W-1:0]         cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               action,
    input  wire logic [IDX_W-1:0]         cell_index,
    input  wire logic [CODE_W-1:0]        cell_code,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DIST_W-1:0]      distance,
    output logic [IDX_W-1:0]              seed_index
);

    localparam int W_RST = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
    localparam int H_RST = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

    logic [DIM_W-1:0] w_reg, w_next, h_reg, h_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;
    logic             eng_ready, rsp_valid, accept;
    req_t             req;
    rsp_t             rsp;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        if (v == '0)
            return DIM_W'(1);
        else if (int'(v) > maxv)
            return DIM_W'(maxv);
        else
            return v;
    endfunction

    assign req.action     = action;
    assign req.cell_index = cell_index;
    assign req.cell_code  = cell_code;

    assign in_stall = !(eng_ready && (!out_valid_reg || !out_stall));
    assign accept   = in_valid && !in_stall;

    gwd_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_w    (w_reg),
        .grid_h    (h_reg),
        .req_valid (accept),
        .req       (req),
        .ready     (eng_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    always_comb
    begin
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                w_next = clamp_dim(cfg_data, MAX_WIDTH);
            else
                h_next = clamp_dim(cfg_data, MAX_HEIGHT);
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        // write and unused requests answer at once with an all-zero result
        if (accept && action != ACT_RUN && action != ACT_READ)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
        end
        else if (rsp_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= DIM_W'(W_RST);
            h_reg         <= DIM_W'(H_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign distance   = out_reg.distance;
    assign seed_index = out_reg.seed_index;

endmodule

`default_nettype wire
